// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the block's checkers. Each macro
// expects clk and rst in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while in reset
`define KJ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyboard/joystick port check failed");

// Next-cycle implication, skipped while in reset
`define KJ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyboard/joystick port check failed");

`endif

// ===== src/kjio_pkg.sv =====
// ---------------------------------------------------------------------------
// kjio_pkg
// Types, port codes and reset values shared by the keyboard/joystick I/O
// port block.
// ---------------------------------------------------------------------------
package kjio_pkg;

  // Field widths
  localparam int OPCODE_W = 3;
  localparam int CODE_W   = 6;
  localparam int STICK_W  = 2;
  localparam int AXIS_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int SOUND_W  = 10;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS_LOW  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS_HIGH = 1'd1;

  localparam logic [AXIS_W-1:0] AXIS_LOW_RESET  = 16'd27768;
  localparam logic [AXIS_W-1:0] AXIS_HIGH_RESET = 16'd37767;

  // Transaction kinds
  typedef enum logic [OPCODE_W-1:0] {
    OP_KEY        = 3'd0,
    OP_JOY_BUTTON = 3'd1,
    OP_JOY_AXIS   = 3'd2,
    OP_PORT_WRITE = 3'd3,
    OP_PORT_READ  = 3'd4
  } kjio_op_t;

  // Processor port addresses
  localparam logic [BYTE_W-1:0] PORT_PRINTER = 8'h11;
  localparam logic [BYTE_W-1:0] PORT_VIDEO   = 8'hcf;
  localparam logic [BYTE_W-1:0] PORT_SPEAKER = 8'haf;
  localparam logic [BYTE_W-1:0] PORT_SELECT  = 8'h8f;
  localparam logic [BYTE_W-1:0] PORT_JOY0    = 8'h07;
  localparam logic [BYTE_W-1:0] PORT_JOY1    = 8'h08;
  localparam logic [BYTE_W-1:0] PORT_JOY1_ALIAS = 8'h00;
  localparam logic [BYTE_W-1:0] PORT_JOY0_ALIAS = 8'h01;
  // Key rows sit at 0x80..0x87: upper five address bits
  localparam logic [4:0] PORT_ROW_BASE = 5'b10000;

  // Control-reset combination on key row 0 (active low)
  localparam logic [BYTE_W-1:0] RESET_MASK = 8'h42;

  // Stick numbers that select a joystick
  localparam logic [STICK_W-1:0] STICK_ONE = 2'd1;
  localparam logic [STICK_W-1:0] STICK_TWO = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [CODE_W-1:0]   event_code;
    logic                pressed;
    logic [STICK_W-1:0]  stick_number;
    logic [AXIS_W-1:0]   x_axis;
    logic [AXIS_W-1:0]   y_axis;
    logic [BYTE_W-1:0]   port_address;
    logic [BYTE_W-1:0]   write_data;
  } kjio_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_data;
    logic [SOUND_W-1:0] sound_level;
    logic               printer_strobe;
    logic [BYTE_W-1:0]  printer_byte;
    logic               video_write_strobe;
    logic               video_read_strobe;
    logic [BYTE_W-1:0]  video_register;
    logic [BYTE_W-1:0]  video_data;
    logic               machine_reset;
  } kjio_result_t;

endpackage

// ===== src/kjio_if.sv =====
// ---------------------------------------------------------------------------
// kjio_if
// Valid/ready channels for host events and processor port accesses (in)
// and for per-transaction results (out).
// ---------------------------------------------------------------------------
interface kjio_in_if;
  import kjio_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [CODE_W-1:0]   event_code;
  logic                pressed;
  logic [STICK_W-1:0]  stick_number;
  logic [AXIS_W-1:0]   x_axis;
  logic [AXIS_W-1:0]   y_axis;
  logic [BYTE_W-1:0]   port_address;
  logic [BYTE_W-1:0]   write_data;

  modport source (
    output valid, opcode, event_code, pressed, stick_number, x_axis, y_axis,
           port_address, write_data,
    input  ready
  );
  modport sink (
    input  valid, opcode, event_code, pressed, stick_number, x_axis, y_axis,
           port_address, write_data,
    output ready
  );
endinterface

interface kjio_out_if;
  import kjio_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  read_data;
  logic [SOUND_W-1:0] sound_level;
  logic               printer_strobe;
  logic [BYTE_W-1:0]  printer_byte;
  logic               video_write_strobe;
  logic               video_read_strobe;
  logic [BYTE_W-1:0]  video_register;
  logic [BYTE_W-1:0]  video_data;
  logic               machine_reset;

  modport source (
    output valid, read_data, sound_level, printer_strobe, printer_byte,
           video_write_strobe, video_read_strobe, video_register, video_data,
           machine_reset,
    input  ready
  );
  modport sink (
    input  valid, read_data, sound_level, printer_strobe, printer_byte,
           video_write_strobe, video_read_strobe, video_register, video_data,
           machine_reset,
    output ready
  );
endinterface

// ===== src/keyboard_joystick_io_ports.sv =====
// ---------------------------------------------------------------------------
// keyboard_joystick_io_ports
// I/O port block: keyboard rows, joysticks, video select, printer, speaker.
//
//   Channel  Dir  Handshake      Carries
//   cmd      in   valid/ready    host event or processor port access
//   rsp      out  valid/ready    read data, strobes, sound level, reset flag
//   cfg      in   cfg_write      axis low/high thresholds
//
// One transaction per cycle sustained while results are taken. An accepted
// transaction passes through the input register, then the result register,
// which offers the result. The decode in kjio_exec is one short step between
// the two registers. A stalled result only stops the input register once it
// is full; rst clears control state and resets thresholds and port state.
// ---------------------------------------------------------------------------
module keyboard_joystick_io_ports (
  input  logic                             clk,
  input  logic                             rst,
  kjio_in_if.sink                          cmd,
  kjio_out_if.source                       rsp,
  input  logic                             cfg_write,
  input  logic [kjio_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kjio_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kjio_pkg::*;

  logic         item_valid;
  kjio_item_t   item;
  logic         out_valid;
  kjio_result_t out_data;
  kjio_result_t result;
  logic         advance;

  // Move the held transaction into the result register when it has room
  assign advance   = item_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !item_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.ready) begin
      item_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item.opcode       <= cmd.opcode;
      item.event_code   <= cmd.event_code;
      item.pressed      <= cmd.pressed;
      item.stick_number <= cmd.stick_number;
      item.x_axis       <= cmd.x_axis;
      item.y_axis       <= cmd.y_axis;
      item.port_address <= cmd.port_address;
      item.write_data   <= cmd.write_data;
    end
  end

  kjio_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (advance),
    .item      (item),
    .result    (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // Drive the result channel
  assign rsp.valid              = out_valid;
  assign rsp.read_data          = out_data.read_data;
  assign rsp.sound_level        = out_data.sound_level;
  assign rsp.printer_strobe     = out_data.printer_strobe;
  assign rsp.printer_byte       = out_data.printer_byte;
  assign rsp.video_write_strobe = out_data.video_write_strobe;
  assign rsp.video_read_strobe  = out_data.video_read_strobe;
  assign rsp.video_register     = out_data.video_register;
  assign rsp.video_data         = out_data.video_data;
  assign rsp.machine_reset      = out_data.machine_reset;

endmodule

// ===== src/kjio_exec.sv =====
// ---------------------------------------------------------------------------
// kjio_exec
// Port state (key rows, joystick bytes, video select, speaker) with the
// combinational decode that updates it and forms one result per transaction.
// ---------------------------------------------------------------------------
module kjio_exec (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [kjio_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kjio_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            fire,
  input  kjio_pkg::kjio_item_t            item,
  output kjio_pkg::kjio_result_t          result
);
  import kjio_pkg::*;

  logic [AXIS_W-1:0]            axis_low;
  logic [AXIS_W-1:0]            axis_high;
  logic [7:0][BYTE_W-1:0]       key_rows;
  logic [7:0][BYTE_W-1:0]       key_rows_next;
  logic [1:0][BYTE_W-1:0]       joy_bytes;
  logic [1:0][BYTE_W-1:0]       joy_bytes_next;
  logic [BYTE_W-1:0]            video_select;
  logic [BYTE_W-1:0]            video_select_next;
  // Speaker level is kept as the written byte; the level is that times four
  logic [BYTE_W-1:0]            speaker;
  logic [BYTE_W-1:0]            speaker_next;
  logic [BYTE_W-1:0]            axis_byte;
  logic                         axis_stick;
  logic                         port_is_row;

  assign axis_stick  = item.stick_number[1];
  assign port_is_row = (item.port_address[7:3] == PORT_ROW_BASE);

  // Decode the transaction and work out the next state and the result
  always_comb begin
    key_rows_next     = key_rows;
    joy_bytes_next    = joy_bytes;
    video_select_next = video_select;
    speaker_next      = speaker;
    axis_byte         = joy_bytes[axis_stick];
    result            = '0;

    case (item.opcode)
      OP_KEY: begin
        key_rows_next[item.event_code[5:3]][item.event_code[2:0]] = item.pressed;
        if ((key_rows_next[0] & RESET_MASK) == '0) begin
          result.machine_reset = 1'b1;
          key_rows_next        = '1;
          joy_bytes_next       = '1;
          speaker_next         = '0;
        end
      end
      OP_JOY_BUTTON: begin
        if (item.event_code[5:4] == 2'b00) begin
          joy_bytes_next[item.event_code[3]][item.event_code[2:0]] = item.pressed;
        end
      end
      OP_JOY_AXIS: begin
        if (item.stick_number == STICK_ONE || item.stick_number == STICK_TWO) begin
          axis_byte[0] = !(item.y_axis < axis_low);
          axis_byte[3] = !(item.x_axis < axis_low);
          axis_byte[2] = !(item.y_axis > axis_high);
          axis_byte[1] = !(item.x_axis > axis_high);
          joy_bytes_next[axis_stick] = axis_byte;
        end
      end
      OP_PORT_WRITE: begin
        if (port_is_row) begin
          key_rows_next[item.port_address[2:0]] = item.write_data;
        end else if (item.port_address == PORT_JOY0) begin
          joy_bytes_next[0] = item.write_data;
        end else if (item.port_address == PORT_JOY1) begin
          joy_bytes_next[1] = item.write_data;
        end else if (item.port_address == PORT_SELECT) begin
          video_select_next = item.write_data;
        end else if (item.port_address == PORT_PRINTER) begin
          result.printer_strobe = 1'b1;
          result.printer_byte   = item.write_data;
        end else if (item.port_address == PORT_VIDEO) begin
          result.video_write_strobe = 1'b1;
          result.video_register     = video_select;
          result.video_data         = item.write_data;
        end else if (item.port_address == PORT_SPEAKER) begin
          speaker_next = item.write_data;
        end
      end
      OP_PORT_READ: begin
        if (item.port_address == PORT_VIDEO) begin
          result.video_read_strobe = 1'b1;
          result.video_register    = video_select;
        end else if (port_is_row) begin
          result.read_data = key_rows[item.port_address[2:0]];
        end else if (item.port_address == PORT_JOY1_ALIAS ||
                     item.port_address == PORT_JOY1) begin
          result.read_data = joy_bytes[1];
        end else if (item.port_address == PORT_JOY0_ALIAS ||
                     item.port_address == PORT_JOY0) begin
          result.read_data = joy_bytes[0];
        end
      end
      default: begin
      end
    endcase

    result.sound_level = {speaker_next, 2'b00};
  end

  // Hold thresholds and port state; update on configuration or transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_low     <= AXIS_LOW_RESET;
      axis_high    <= AXIS_HIGH_RESET;
      key_rows     <= '1;
      joy_bytes    <= '1;
      video_select <= '0;
      speaker      <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_AXIS_LOW:  axis_low  <= cfg_data[AXIS_W-1:0];
          REG_AXIS_HIGH: axis_high <= cfg_data[AXIS_W-1:0];
          default: begin
          end
        endcase
      end
      if (fire) begin
        key_rows     <= key_rows_next;
        joy_bytes    <= joy_bytes_next;
        video_select <= video_select_next;
        speaker      <= speaker_next;
      end
    end
  end

endmodule

// ===== src/kjio_checker.sv =====
// ---------------------------------------------------------------------------
// kjio_checker
// Port-level checks on the result channel of the I/O port block, bound to
// the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kjio_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [kjio_pkg::BYTE_W-1:0]   read_data,
  input logic [kjio_pkg::SOUND_W-1:0]  sound_level,
  input logic                          printer_strobe,
  input logic                          video_write_strobe,
  input logic                          video_read_strobe,
  input logic                          machine_reset
);
  import kjio_pkg::*;

  // A pending result stays offered until taken
  `KJ_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid)
  // One transaction touches at most one external device
  `KJ_ASSERT_SAME(a_one_strobe, out_valid, $onehot0({printer_strobe, video_write_strobe, video_read_strobe, machine_reset}))
  // A control reset silences the speaker
  `KJ_ASSERT_SAME(a_reset_quiet, out_valid && machine_reset, sound_level == '0)
  // Video chip reads return no data from this block
  `KJ_ASSERT_SAME(a_vread_zero, out_valid && video_read_strobe, read_data == '0)
  // Sound level is always a multiple of four
  `KJ_ASSERT_SAME(a_sound_step, out_valid, sound_level[1:0] == 2'b00)

endmodule

bind keyboard_joystick_io_ports kjio_checker u_kjio_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (rsp.valid),
  .out_ready          (rsp.ready),
  .read_data          (rsp.read_data),
  .sound_level        (rsp.sound_level),
  .printer_strobe     (rsp.printer_strobe),
  .video_write_strobe (rsp.video_write_strobe),
  .video_read_strobe  (rsp.video_read_strobe),
  .machine_reset      (rsp.machine_reset)
);
